>>> rtl/core/tksi_pkg.sv
// Package for the top-k score insertion list: list depth, widths, op codes
// and the command struct between controller and datapath.
// No dependencies.
package tksi_pkg;

  localparam int KEEP_DEPTH = 10;
  localparam int CNT_W      = $clog2(KEEP_DEPTH + 1);
  localparam int IDX_W      = $clog2(KEEP_DEPTH);

  // Port widths fixed by the interface
  localparam int OP_W    = 2;
  localparam int COORD_W = 16;
  localparam int SCORE_W = 32;
  localparam int TAG_W   = 16;
  localparam int RIDX_W  = 4;
  localparam int OCNT_W  = 4;

  // Operation codes; code 3 is unused and behaves as a no-op
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef struct packed {
    logic               [SCORE_W-1:0] score;
    logic               [COORD_W-1:0] x;
    logic               [COORD_W-1:0] y;
    logic               [TAG_W-1:0]   tag;
  } tksi_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the incoming word
    logic exec;   // apply the op and register the result
  } tksi_cmd_t;

endpackage

>>> rtl/core/tksi_ctrl.sv
// Sequencer for the top-k list: accept, execute, present result.
// Depends on tksi_pkg.
module tksi_ctrl import tksi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output tksi_cmd_t cmd,
  output logic      out_strobe
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } tksi_state_t;

  tksi_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cmd.load   = start && !busy;
  assign cmd.exec   = (state_r == ST_EXEC);
  assign out_strobe = (state_r == ST_RESP);

`ifndef NO_ASSERTIONS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_EXEC))
    else $error("accepted word did not enter execute");
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(cmd.exec))
    else $error("result strobe without prior execute");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy)
    else $error("result strobe longer than one cycle");
`endif

endmodule

>>> rtl/core/tksi_dpath.sv
// Datapath for the top-k list: input word register, row of compare-and-shift
// cells, held count and result registers. Depends on tksi_pkg.
module tksi_dpath import tksi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tksi_cmd_t                 cmd,
  input  logic [OP_W-1:0]           in_operation,
  input  logic [COORD_W-1:0]        in_point_x,
  input  logic [COORD_W-1:0]        in_point_y,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic [TAG_W-1:0]          in_tag_in,
  input  logic [RIDX_W-1:0]         in_read_index,
  output logic                      out_entry_valid,
  output logic signed [SCORE_W-1:0] out_entry_score,
  output logic [COORD_W-1:0]        out_entry_x,
  output logic [COORD_W-1:0]        out_entry_y,
  output logic [TAG_W-1:0]          out_entry_tag,
  output logic [OCNT_W-1:0]         out_entry_count
);

  // captured word
  logic [OP_W-1:0]           op_r;
  logic [COORD_W-1:0]        x_r;
  logic [COORD_W-1:0]        y_r;
  logic signed [SCORE_W-1:0] score_r;
  logic [TAG_W-1:0]          tag_r;
  logic [RIDX_W-1:0]         ridx_r;

  tksi_entry_t slot_r [KEEP_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [KEEP_DEPTH-1:0] gt;        // new score beats held entry
  logic [KEEP_DEPTH-1:0] take_new;
  logic [KEEP_DEPTH-1:0] shift_in;
  logic                  do_ins;
  logic                  full;
  logic                  rd_hit;
  tksi_entry_t           new_entry;
  tksi_entry_t           rd_entry;

  logic                      valid_r;
  logic signed [SCORE_W-1:0] rscore_r;
  logic [COORD_W-1:0]        rx_r;
  logic [COORD_W-1:0]        ry_r;
  logic [TAG_W-1:0]          rtag_r;
  logic [OCNT_W-1:0]         rcount_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      x_r     <= in_point_x;
      y_r     <= in_point_y;
      score_r <= in_score;
      tag_r   <= in_tag_in;
      ridx_r  <= in_read_index;
    end
  end

  assign full      = (count_r == CNT_W'(KEEP_DEPTH));
  assign do_ins    = cmd.exec && (op_r == OP_INSERT) && (score_r != '0);
  assign new_entry = '{score: score_r, x: x_r, y: y_r, tag: tag_r};

  // List is sorted, so gt is a run of ones from the insert point to the tail.
  always_comb begin
    for (int i = 0; i < KEEP_DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < count_r) && (score_r > $signed(slot_r[i].score));
    end
    for (int i = 0; i < KEEP_DEPTH; i++) begin
      if (i == 0) begin
        take_new[i] = gt[i] || (count_r == '0);
        shift_in[i] = 1'b0;
      end else begin
        take_new[i] = !gt[i-1] && (gt[i] || (count_r == CNT_W'(i)));
        shift_in[i] = gt[i-1] && (CNT_W'(i) <= count_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      for (int i = 0; i < KEEP_DEPTH; i++) begin
        if (shift_in[i] && i > 0) begin
          slot_r[i] <= slot_r[(i > 0) ? i - 1 : 0];
        end else if (take_new[i]) begin
          slot_r[i] <= new_entry;
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (op_r == OP_CLEAR) begin
      count_nxt = '0;
    end else if ((op_r == OP_INSERT) && (score_r != '0) && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign rd_hit   = (op_r == OP_READ) && (8'(ridx_r) < 8'(count_r));
  assign rd_entry = slot_r[ridx_r[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      valid_r  <= rd_hit;
      rscore_r <= rd_hit ? $signed(rd_entry.score) : '0;
      rx_r     <= rd_hit ? rd_entry.x : '0;
      ry_r     <= rd_hit ? rd_entry.y : '0;
      rtag_r   <= rd_hit ? rd_entry.tag : '0;
      rcount_r <= OCNT_W'(count_nxt);
    end
  end

  assign out_entry_valid = valid_r;
  assign out_entry_score = rscore_r;
  assign out_entry_x     = rx_r;
  assign out_entry_y     = ry_r;
  assign out_entry_tag   = rtag_r;
  assign out_entry_count = rcount_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(KEEP_DEPTH))
    else $error("held count exceeds list depth");
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == OP_CLEAR) |=> (count_r == '0))
    else $error("clear left entries held");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r != OP_CLEAR) |=> (count_r == $past(count_r)
      || count_r == $past(count_r) + CNT_W'(1)))
    else $error("held count moved by more than one");
`endif

endmodule

>>> rtl/core/top_k_score_insert_unit.sv
// Top level of the top-k score insertion list.
// Depends on tksi_pkg, tksi_ctrl and tksi_dpath.
//
// Keeps the KEEP_DEPTH best scored points (score, x, y, tag) sorted by
// descending score. A command word is taken at a rising edge with start
// high and busy low. Ops: insert (score zero is ignored, ties go after
// existing entries, the tail drops out when full), clear, and read at
// in_read_index.
// Every word gives exactly one result word: out_strobe is high for one
// cycle, in the present state after the execute state, with the read fields
// (zero unless a read hits a held entry) and the count after the op.
// Accept, execute and present run in turn; new words are taken in idle;
// busy is high while a word is in execute or its result is on the ports.
// The insert itself is done in execute: every list cell compares against
// the new score in parallel and either keeps, shifts down or takes the new
// point. The receiver cannot stall: results hold until the next execute.
// Reset (rst_n low, synchronous) empties the list and returns to idle;
// slot contents are not cleared, an empty slot is never read out.
module top_k_score_insert_unit import tksi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [OP_W-1:0]           in_operation,
  input  logic [COORD_W-1:0]        in_point_x,
  input  logic [COORD_W-1:0]        in_point_y,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic [TAG_W-1:0]          in_tag_in,
  input  logic [RIDX_W-1:0]         in_read_index,
  output logic                      out_strobe,
  output logic                      out_entry_valid,
  output logic signed [SCORE_W-1:0] out_entry_score,
  output logic [COORD_W-1:0]        out_entry_x,
  output logic [COORD_W-1:0]        out_entry_y,
  output logic [TAG_W-1:0]          out_entry_tag,
  output logic [OCNT_W-1:0]         out_entry_count
);

  tksi_cmd_t cmd;

  // sequencer
  tksi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .out_strobe (out_strobe)
  );

  // list cells and result registers
  tksi_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_score        (in_score),
    .in_tag_in       (in_tag_in),
    .in_read_index   (in_read_index),
    .out_entry_valid (out_entry_valid),
    .out_entry_score (out_entry_score),
    .out_entry_x     (out_entry_x),
    .out_entry_y     (out_entry_y),
    .out_entry_tag   (out_entry_tag),
    .out_entry_count (out_entry_count)
  );

endmodule
